@@ hdl/lseg_pkg.sv @@
// ----------------------------------------------------------------------------
// lseg_pkg
// Types, codes and helpers shared by the LED strip effect generator.
// ----------------------------------------------------------------------------
package lseg_pkg;

	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned CfgDataW = 8;
	localparam int unsigned ColorW = 8;
	localparam int unsigned PixW = 6;
	localparam int unsigned CountW = 7;
	localparam int unsigned StepW = 8;
	localparam int unsigned ShiftW = 4;

	typedef enum logic [1:0] {
		MODE_CHASE = 2'd0,
		MODE_WAVE  = 2'd1,
		MODE_PULSE = 2'd2,
		MODE_OFF   = 2'd3
	} mode_t;

	typedef enum logic [CfgIdxW-1:0] {
		REG_EFFECT_MODE = 3'd0,
		REG_BASE_RED    = 3'd1,
		REG_BASE_GREEN  = 3'd2,
		REG_BASE_BLUE   = 3'd3,
		REG_LED_COUNT   = 3'd4,
		REG_LOOP_LENGTH = 3'd5,
		REG_RSVD6       = 3'd6,
		REG_RSVD7       = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [ColorW-1:0] r;
		logic [ColorW-1:0] g;
		logic [ColorW-1:0] b;
	} rgb_t;

	localparam logic [ColorW-1:0] White = 8'hff;

	// right shift of an 8-bit level; a shift of 8 or more gives black
	function automatic logic [ColorW-1:0] shr8(input logic [ColorW-1:0] v,
			input logic [ShiftW-1:0] n);
		logic [ColorW-1:0] res;
		if (n >= 4'd8) begin
			res = '0;
		end else begin
			res = v >> n;
		end
		return res;
	endfunction

	function automatic rgb_t shr_rgb(input rgb_t c, input logic [ShiftW-1:0] n);
		rgb_t res;
		res.r = shr8(c.r, n);
		res.g = shr8(c.g, n);
		res.b = shr8(c.b, n);
		return res;
	endfunction

endpackage

@@ hdl/led_strip_effect_generator.sv @@
// ----------------------------------------------------------------------------
// led_strip_effect_generator
// Renders one LED strip frame per tick, one RGB pixel per output beat.
// ----------------------------------------------------------------------------
// A tick beat with frame_tick set starts a frame of min(led_count, MAX_LEDS)
// pixel beats, pixel 0 first, the final one flagged by last_pixel (and by
// loop_end when the step counter wraps after that frame). The pixel counter
// loads one pixel into the output register per cycle when the output side
// never stalls; the next tick beat is taken in the same cycle the final pixel
// is loaded, so frames run back to back. A tick beat with frame_tick clear,
// or a frame with zero pixels, produces no pixel beats. Configuration writes
// are always ready and must only be issued while no frame is in flight.
module led_strip_effect_generator #(
	parameter int unsigned MAX_LEDS = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [lseg_pkg::CfgIdxW-1:0]      cfg_index,
	input  logic [lseg_pkg::CfgDataW-1:0]     cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              frame_tick,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [lseg_pkg::PixW-1:0]         pixel_index,
	output logic [lseg_pkg::ColorW-1:0]       red,
	output logic [lseg_pkg::ColorW-1:0]       green,
	output logic [lseg_pkg::ColorW-1:0]       blue,
	output logic                              last_pixel,
	output logic                              loop_end
);

	localparam logic [lseg_pkg::CountW-1:0] MaxN = lseg_pkg::CountW'(MAX_LEDS);

	// configuration
	lseg_pkg::mode_t                   mode_q;
	lseg_pkg::rgb_t                    base_q;
	logic [lseg_pkg::CountW-1:0]       led_count_q;
	logic [lseg_pkg::StepW-1:0]        loop_len_q;

	// frame state
	logic [lseg_pkg::StepW-1:0]        step_q;
	logic [lseg_pkg::StepW-1:0]        frame_step_q;
	logic [lseg_pkg::CountW-1:0]       frame_n_q;
	logic                              frame_wrap_q;
	logic                              busy_q;
	logic [lseg_pkg::PixW-1:0]         pix_q;

	logic                              in_acc;
	logic                              adv;
	logic                              last;
	logic [lseg_pkg::CountW-1:0]       n_sat;
	logic [lseg_pkg::StepW:0]          step_inc;
	logic                              wrap;
	logic [lseg_pkg::ShiftW-1:0]       delta;
	logic [4:0]                        wave_y;
	logic [lseg_pkg::ShiftW-1:0]       wave_sh;
	lseg_pkg::rgb_t                    pix_rgb;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= lseg_pkg::MODE_CHASE;
			base_q      <= '{r: 8'hff, g: 8'h00, b: 8'h00};
			led_count_q <= 7'd64;
			loop_len_q  <= 8'd128;
		end else if (cfg_valid) begin
			unique case (lseg_pkg::reg_idx_t'(cfg_index))
				lseg_pkg::REG_EFFECT_MODE: mode_q <= lseg_pkg::mode_t'(cfg_data[1:0]);
				lseg_pkg::REG_BASE_RED:    base_q.r <= cfg_data;
				lseg_pkg::REG_BASE_GREEN:  base_q.g <= cfg_data;
				lseg_pkg::REG_BASE_BLUE:   base_q.b <= cfg_data;
				lseg_pkg::REG_LED_COUNT:   led_count_q <= cfg_data[lseg_pkg::CountW-1:0];
				lseg_pkg::REG_LOOP_LENGTH: loop_len_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// frame setup at tick time
	assign n_sat    = (led_count_q > MaxN) ? MaxN : led_count_q;
	assign step_inc = {1'b0, step_q} + 9'd1;
	assign wrap     = step_inc >= {1'b0, loop_len_q};

	// pixel sequencing
	assign adv      = busy_q && (!out_valid || out_ready);
	assign last     = ({1'b0, pix_q} + 7'd1) == frame_n_q;
	assign in_ready = !busy_q || (adv && last);
	assign in_acc   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q       <= '0;
			frame_step_q <= '0;
			frame_n_q    <= '0;
			frame_wrap_q <= 1'b0;
			busy_q       <= 1'b0;
			pix_q        <= '0;
		end else if (in_acc && frame_tick) begin
			step_q       <= wrap ? '0 : step_inc[lseg_pkg::StepW-1:0];
			frame_step_q <= step_q;
			frame_n_q    <= n_sat;
			frame_wrap_q <= wrap;
			pix_q        <= '0;
			busy_q       <= (n_sat != '0);
		end else if (adv) begin
			pix_q <= pix_q + 6'd1;
			if (last) begin
				busy_q <= 1'b0;
			end
		end
	end

	// pixel color
	always_comb begin
		logic [lseg_pkg::StepW-1:0] inv;
		inv = 8'd128 - frame_step_q;
		priority if (frame_step_q > 8'd128) begin
			delta = '0;
		end else if (frame_step_q > 8'd64) begin
			delta = lseg_pkg::ShiftW'(inv >> 3);
		end else begin
			delta = lseg_pkg::ShiftW'(frame_step_q >> 3);
		end
	end

	assign wave_y = pix_q[4:0] + frame_step_q[4:0];

	always_comb begin
		priority if (wave_y >= 5'd24) begin
			wave_sh = lseg_pkg::ShiftW'(wave_y - 5'd24);
		end else if (wave_y >= 5'd16) begin
			wave_sh = lseg_pkg::ShiftW'(5'd24 - wave_y);
		end else if (wave_y >= 5'd8) begin
			wave_sh = lseg_pkg::ShiftW'(wave_y - 5'd8);
		end else begin
			wave_sh = lseg_pkg::ShiftW'(5'd8 - wave_y);
		end
	end

	always_comb begin
		lseg_pkg::rgb_t white;
		white = '{r: lseg_pkg::White, g: lseg_pkg::White, b: lseg_pkg::White};
		unique case (mode_q)
			lseg_pkg::MODE_CHASE:
				pix_rgb = ({2'b00, pix_q} == frame_step_q) ? base_q : '0;
			lseg_pkg::MODE_WAVE:
				pix_rgb = (wave_y >= 5'd16) ? lseg_pkg::shr_rgb(white, wave_sh)
					: lseg_pkg::shr_rgb(base_q, wave_sh);
			lseg_pkg::MODE_PULSE:
				pix_rgb = lseg_pkg::shr_rgb(base_q, delta);
			default:
				pix_rgb = '0;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pixel_index <= pix_q;
			red         <= pix_rgb.r;
			green       <= pix_rgb.g;
			blue        <= pix_rgb.b;
			last_pixel  <= last;
			loop_end    <= last && frame_wrap_q;
		end
	end

	// checks
	a_pix_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> ({1'b0, pix_q} < frame_n_q))
		else $error("pixel counter beyond frame length");

	a_ready_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ready && busy_q) |-> (adv && last))
		else $error("tick taken mid-frame");

	a_pix_step: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && !last) |=> (busy_q && pix_q == $past(pix_q) + 6'd1))
		else $error("pixel counter skipped");

	a_loop_end_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && loop_end) |-> last_pixel)
		else $error("loop_end without last_pixel");

	a_frame_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && frame_tick && n_sat != '0) |=> (busy_q && pix_q == '0))
		else $error("frame did not start");

endmodule
